// File: hdl/cbe_pkg.sv
// Shared types, constants and helper functions of the cubic bezier easing solver.
// Used by the register block, the controller, the datapath, the top level and the testbench.
// Depends on nothing else.
package cbe_pkg;

  // Default iteration limits of the solver.
  localparam int unsigned NEWTON_STEPS_DEF = 8;
  localparam int unsigned BISECT_STEPS_DEF = 32;

  // Widths.
  localparam int unsigned IW       = 19;  // progress and eased value, signed Q.16
  localparam int unsigned XW       = 17;  // x control points, unsigned Q.16
  localparam int unsigned QF       = 30;  // fraction bits of the internal format
  localparam int unsigned QIN_SH   = 14;  // Q.16 to Q.30 shift
  localparam int unsigned VW       = 38;  // accumulator and error width
  localparam int unsigned AW       = 32;  // multiplier operand A (t-like values)
  localparam int unsigned BW       = 34;  // multiplier operand B (control points)
  localparam int unsigned DIV_BITS = 32;  // Newton quotient bits
  localparam int unsigned DCW      = 5;   // divider step counter
  localparam int unsigned PCW      = 3;   // micro-op counter
  localparam int unsigned AddrW    = 5;   // APB address
  localparam int unsigned DataW    = 32;  // APB data

  // Numeric constants.
  localparam logic signed [AW-1:0] Q_ONE_A  = AW'(64'd1 << QF);
  localparam logic signed [BW-1:0] Q_ONE_B  = BW'(64'd1 << QF);
  localparam logic [VW-1:0]        EPS      = VW'(107);
  localparam logic [VW-1:0]        RND_HALF = VW'(8192);
  localparam logic signed [IW-1:0] ONE16    = IW'(65536);
  localparam logic signed [VW-1:0] OUT_MIN  = -VW'(131072);
  localparam logic signed [VW-1:0] OUT_MAX  = VW'(196608);
  localparam logic [XW-1:0]        X_MAX    = XW'(65536);

  // Mode codes.
  localparam logic [1:0] MODE_LINEAR = 2'd0;
  localparam logic [1:0] MODE_HOLD   = 2'd1;
  localparam logic [1:0] MODE_BEZIER = 2'd2;

  // Register indexes.
  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_X1   = 3'd1;
  localparam logic [2:0] REG_Y1   = 3'd2;
  localparam logic [2:0] REG_X2   = 3'd3;
  localparam logic [2:0] REG_Y2   = 3'd4;

  // Last micro-op of each program.
  localparam logic [PCW-1:0] EVAL_LAST  = PCW'(7);
  localparam logic [PCW-1:0] SLOPE_LAST = PCW'(2);

  typedef struct packed {
    logic [1:0]           mode;
    logic [XW-1:0]        x1;
    logic signed [IW-1:0] y1;
    logic [XW-1:0]        x2;
    logic signed [IW-1:0] y2;
  } cfg_t;

  typedef enum logic [2:0] {SA_MT, SA_T, SA_M1, SA_M4, SA_M7, SA_SCR} sel_a_e;
  typedef enum logic [2:0] {SB_MT, SB_T, SB_P1, SB_P2, SB_PD, SB_PC} sel_b_e;
  typedef enum logic [2:0] {
    DST_M1, DST_M4, DST_M7, DST_SCR, DST_ACC1, DST_ACC3, DST_ACC6
  } dst_e;

  typedef struct packed {
    sel_a_e a;
    sel_b_e b;
    dst_e   dst;
  } uop_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_N_EVAL, ST_N_CHK, ST_N_SLOPE, ST_N_DCHK, ST_N_DIV, ST_N_UPD,
    ST_B_EVAL, ST_B_CHK, ST_Y_EVAL, ST_Y_OUT
  } state_e;

  typedef struct packed {
    logic accept;
    logic mul_en;
    logic wb_en;
    logic acc_clr;
    uop_t uop;
    logic axis_y;
    logic save_err;
    logic div_load;
    logic div_step;
    logic t_upd;
    logic init_bisect;
    logic bis_upd;
    logic res_ld;
    logic res_fast;
  } cmd_t;

  typedef struct packed {
    logic fast;
    logic err_small;
    logic d_small;
    logic stray;
    logic t_out;
  } sts_t;

  // Curve value: 3(1-t)^2 t p1 + 3(1-t) t^2 p2 + t^3.
  function automatic uop_t eval_uop(input logic [PCW-1:0] pc);
    uop_t u;
    unique case (pc)
      3'd0: u = '{a: SA_MT,  b: SB_MT, dst: DST_M1};
      3'd1: u = '{a: SA_M1,  b: SB_T,  dst: DST_SCR};
      3'd2: u = '{a: SA_SCR, b: SB_P1, dst: DST_ACC3};
      3'd3: u = '{a: SA_MT,  b: SB_T,  dst: DST_M4};
      3'd4: u = '{a: SA_M4,  b: SB_T,  dst: DST_SCR};
      3'd5: u = '{a: SA_SCR, b: SB_P2, dst: DST_ACC3};
      3'd6: u = '{a: SA_T,   b: SB_T,  dst: DST_M7};
      3'd7: u = '{a: SA_M7,  b: SB_T,  dst: DST_ACC1};
      default: u = '{a: SA_MT, b: SB_MT, dst: DST_M1};
    endcase
    return u;
  endfunction

  // Slope: 3(1-t)^2 p1 + 6(1-t) t (p2-p1) + 3 t^2 (1-p2), reusing the products of the curve.
  function automatic uop_t slope_uop(input logic [PCW-1:0] pc);
    uop_t u;
    unique case (pc)
      3'd0:    u = '{a: SA_M1, b: SB_P1, dst: DST_ACC3};
      3'd1:    u = '{a: SA_M4, b: SB_PD, dst: DST_ACC6};
      default: u = '{a: SA_M7, b: SB_PC, dst: DST_ACC3};
    endcase
    return u;
  endfunction

  function automatic logic [VW-1:0] abs_v(input logic signed [VW-1:0] v);
    return v[VW-1] ? VW'(-v) : VW'(v);
  endfunction

  function automatic logic signed [IW-1:0] sat_out(input logic signed [VW-1:0] v);
    logic signed [IW-1:0] r;
    if (v < OUT_MIN) r = IW'(OUT_MIN);
    else if (v > OUT_MAX) r = IW'(OUT_MAX);
    else r = IW'(v);
    return r;
  endfunction

endpackage

// File: hdl/cubic_bezier_easing_solver.sv
// Linear, hold and clamped bezier items give their result in the cycle after start is taken.
// A solved item runs each curve evaluation and check on the one shared multiplier, and each
// Newton step adds the slope and the radix-2 divider; bisection steps follow when Newton
// gives up, and a final y evaluation gives the result.
// Throughput: one solved item at a time; start is taken whenever busy is low.
// Reset is asynchronous and active low; it restores the register defaults and idles the solver.
module cubic_bezier_easing_solver
  import cbe_pkg::*;
#(
  parameter int unsigned NEWTON_STEPS = NEWTON_STEPS_DEF,
  parameter int unsigned BISECT_STEPS = BISECT_STEPS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration port.
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrW-1:0]     paddr,
  input  logic [DataW-1:0]     pwdata,
  output logic [DataW-1:0]     prdata,
  output logic                 pready,
  // Item interface.
  input  logic                 start,
  output logic                 busy,
  input  logic signed [IW-1:0] progress_i,
  output logic                 done_o,
  output logic signed [IW-1:0] eased_value_o
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  // Writes always complete in the access cycle.
  assign pready = 1'b1;

  // Mode, control points: users change them only while idle; the block does not enforce it.
  cbe_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  // The controller walks the micro-op programs for the curve and its slope, runs the
  // divider for each Newton step and falls back to bisection when Newton gives up.
  cbe_ctrl #(
    .NEWTON_STEPS (NEWTON_STEPS),
    .BISECT_STEPS (BISECT_STEPS)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // The datapath holds t, the bisection bounds, the accumulator and the divider, and
  // registers each result, so done_o and eased_value_o are valid together for one cycle.
  cbe_dp u_dp (
    .clk_i         (clk_i),
    .cfg_i         (cfg),
    .progress_i    (progress_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .eased_value_o (eased_value_o)
  );

endmodule

// File: hdl/cbe_regs.sv
// APB register block of the easing solver: mode and the two control points.
// Depends on cbe_pkg.
module cbe_regs
  import cbe_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output cfg_t             cfg_o
);

  cfg_t          cfg_q;
  logic [2:0]    idx;
  logic          wr;
  logic [XW-1:0] x_wr;

  assign idx  = paddr[AddrW-1:2];
  assign wr   = psel && penable && pwrite;
  // X coordinates are taken from the low XW bits of the write data; values above one are clamped to one.
  assign x_wr = (pwdata[XW-1:0] > X_MAX) ? X_MAX : pwdata[XW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode <= MODE_LINEAR;
      cfg_q.x1   <= '0;
      cfg_q.y1   <= '0;
      cfg_q.x2   <= X_MAX;
      cfg_q.y2   <= ONE16;
    end else if (wr) begin
      unique case (idx)
        REG_MODE: cfg_q.mode <= pwdata[1:0];
        REG_X1:   cfg_q.x1   <= x_wr;
        REG_Y1:   cfg_q.y1   <= pwdata[IW-1:0];
        REG_X2:   cfg_q.x2   <= x_wr;
        REG_Y2:   cfg_q.y2   <= pwdata[IW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MODE: prdata = DataW'(cfg_q.mode);
      REG_X1:   prdata = DataW'(cfg_q.x1);
      REG_Y1:   prdata = DataW'(cfg_q.y1);
      REG_X2:   prdata = DataW'(cfg_q.x2);
      REG_Y2:   prdata = DataW'(cfg_q.y2);
      default:  prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: hdl/cbe_ctrl.sv
// Controller of the easing solver: sequences curve evaluations, Newton steps,
// the divider, bisection and the final y evaluation. Depends on cbe_pkg.
module cbe_ctrl
  import cbe_pkg::*;
#(
  parameter int unsigned NEWTON_STEPS = NEWTON_STEPS_DEF,
  parameter int unsigned BISECT_STEPS = BISECT_STEPS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  output logic done_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam int unsigned NCW = $clog2(NEWTON_STEPS + 1);
  localparam int unsigned BCW = $clog2(BISECT_STEPS + 1);

  state_e         state_q, state_d;
  logic [PCW-1:0] pc_q, pc_d;
  logic           ph_q, ph_d;
  logic [NCW-1:0] ncnt_q, ncnt_d;
  logic [BCW-1:0] bcnt_q, bcnt_d;
  logic [DCW-1:0] dcnt_q, dcnt_d;
  logic           done_q;
  logic [PCW-1:0] last;
  state_e         after;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= '0;
      ph_q    <= 1'b0;
      ncnt_q  <= '0;
      bcnt_q  <= '0;
      dcnt_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      ph_q    <= ph_d;
      ncnt_q  <= ncnt_d;
      bcnt_q  <= bcnt_d;
      dcnt_q  <= dcnt_d;
      done_q  <= cmd_o.res_ld;
    end
  end

  always_comb begin
    state_d      = state_q;
    pc_d         = pc_q;
    ph_d         = ph_q;
    ncnt_d       = ncnt_q;
    bcnt_d       = bcnt_q;
    dcnt_d       = dcnt_q;
    cmd_o        = '0;
    cmd_o.uop    = (state_q == ST_N_SLOPE) ? slope_uop(pc_q) : eval_uop(pc_q);
    cmd_o.axis_y = (state_q == ST_Y_EVAL);
    last         = (state_q == ST_N_SLOPE) ? SLOPE_LAST : EVAL_LAST;

    unique case (state_q)
      ST_N_EVAL:  after = ST_N_CHK;
      ST_N_SLOPE: after = ST_N_DCHK;
      ST_B_EVAL:  after = ST_B_CHK;
      default:    after = ST_Y_OUT;
    endcase

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          if (sts_i.fast) begin
            cmd_o.res_ld   = 1'b1;
            cmd_o.res_fast = 1'b1;
          end else begin
            state_d = ST_N_EVAL;
            pc_d    = '0;
            ph_d    = 1'b0;
            ncnt_d  = '0;
          end
        end
      end
      ST_N_EVAL, ST_N_SLOPE, ST_B_EVAL, ST_Y_EVAL: begin
        // Each micro-op has a multiply phase and then a write-back phase in the next cycle.
        cmd_o.mul_en  = !ph_q;
        cmd_o.wb_en   = ph_q;
        cmd_o.acc_clr = !ph_q && (pc_q == '0);
        ph_d          = !ph_q;
        if (ph_q) begin
          if (pc_q == last) begin
            pc_d    = '0;
            state_d = after;
          end else begin
            pc_d = pc_q + PCW'(1);
          end
        end
      end
      ST_N_CHK: begin
        if (sts_i.err_small) begin
          state_d = ST_Y_EVAL;
        end else begin
          cmd_o.save_err = 1'b1;
          state_d        = ST_N_SLOPE;
        end
      end
      ST_N_DCHK: begin
        if (sts_i.d_small || sts_i.stray) begin
          cmd_o.init_bisect = 1'b1;
          bcnt_d            = '0;
          state_d           = ST_B_EVAL;
        end else begin
          cmd_o.div_load = 1'b1;
          dcnt_d         = '0;
          state_d        = ST_N_DIV;
        end
      end
      ST_N_DIV: begin
        cmd_o.div_step = 1'b1;
        dcnt_d         = dcnt_q + DCW'(1);
        if (dcnt_q == DCW'(DIV_BITS - 1)) state_d = ST_N_UPD;
      end
      ST_N_UPD: begin
        if (sts_i.t_out || ncnt_q == NCW'(NEWTON_STEPS - 1)) begin
          cmd_o.init_bisect = 1'b1;
          bcnt_d            = '0;
          state_d           = ST_B_EVAL;
        end else begin
          cmd_o.t_upd = 1'b1;
          ncnt_d      = ncnt_q + NCW'(1);
          state_d     = ST_N_EVAL;
        end
      end
      ST_B_CHK: begin
        if (sts_i.err_small) begin
          state_d = ST_Y_EVAL;
        end else begin
          cmd_o.bis_upd = 1'b1;
          if (bcnt_q == BCW'(BISECT_STEPS - 1)) begin
            state_d = ST_Y_EVAL;
          end else begin
            bcnt_d  = bcnt_q + BCW'(1);
            state_d = ST_B_EVAL;
          end
        end
      end
      ST_Y_OUT: begin
        cmd_o.res_ld = 1'b1;
        state_d      = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;

endmodule

// File: hdl/cbe_dp.sv
// Datapath of the easing solver: shared Q2.30 by Q4.30 multiplier, accumulator,
// radix-2 divider, Newton and bisection updates, rounding. Depends on cbe_pkg.
module cbe_dp
  import cbe_pkg::*;
(
  input  logic                 clk_i,
  input  cfg_t                 cfg_i,
  input  logic signed [IW-1:0] progress_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  output logic signed [IW-1:0] eased_value_o
);

  localparam int unsigned PW  = AW + BW;
  localparam int unsigned TNW = DIV_BITS + 3;

  logic signed [VW-1:0] x_q, acc_q, prod_q, err_q;
  logic signed [AW-1:0] t_q, lo_q, hi_q, m1_q, m4_q, m7_q, scr_q;
  logic [VW-1:0]        rem_q, dvs_q;
  logic [DIV_BITS-1:0]  dvd_q, quot_q;
  logic                 neg_q;
  logic signed [IW-1:0] res_q;

  logic signed [AW-1:0]  mt, op_a, lo_n, hi_n, mid;
  logic signed [BW-1:0]  px1, px2, py1, py2, p1, p2, pd, pc, op_b;
  logic signed [PW-1:0]  full, bias, adj;
  logic signed [VW-1:0]  prod_c, err_c, y_rnd;
  logic [VW-1:0]         err_abs, d_abs, ymag, rmag;
  logic [VW:0]           rem2;
  logic                  ge, cur_lt;
  logic signed [TNW-1:0] qs, tn;
  logic [AW:0]           sum;
  logic signed [IW-1:0]  fast_val;

  assign mt  = Q_ONE_A - t_q;
  assign px1 = signed'({{(BW-XW-QIN_SH){1'b0}}, cfg_i.x1, {QIN_SH{1'b0}}});
  assign px2 = signed'({{(BW-XW-QIN_SH){1'b0}}, cfg_i.x2, {QIN_SH{1'b0}}});
  assign py1 = signed'({{(BW-IW-QIN_SH){cfg_i.y1[IW-1]}}, cfg_i.y1, {QIN_SH{1'b0}}});
  assign py2 = signed'({{(BW-IW-QIN_SH){cfg_i.y2[IW-1]}}, cfg_i.y2, {QIN_SH{1'b0}}});
  assign p1  = cmd_i.axis_y ? py1 : px1;
  assign p2  = cmd_i.axis_y ? py2 : px2;
  assign pd  = px2 - px1;
  assign pc  = Q_ONE_B - px2;

  always_comb begin
    unique case (cmd_i.uop.a)
      SA_MT:   op_a = mt;
      SA_T:    op_a = t_q;
      SA_M1:   op_a = m1_q;
      SA_M4:   op_a = m4_q;
      SA_M7:   op_a = m7_q;
      SA_SCR:  op_a = scr_q;
      default: op_a = '0;
    endcase
    unique case (cmd_i.uop.b)
      SB_MT:   op_b = BW'(mt);
      SB_T:    op_b = BW'(t_q);
      SB_P1:   op_b = p1;
      SB_P2:   op_b = p2;
      SB_PD:   op_b = pd;
      SB_PC:   op_b = pc;
      default: op_b = '0;
    endcase
  end

  // Product scaled by 2^-30, truncated toward zero.
  assign full   = op_a * op_b;
  assign bias   = full[PW-1] ? PW'((64'd1 << QF) - 64'd1) : '0;
  assign adj    = full + bias;
  assign prod_c = VW'(adj >>> QF);

  assign err_c   = acc_q - x_q;
  assign err_abs = abs_v(err_q);
  assign d_abs   = abs_v(acc_q);

  // One quotient bit per cycle.
  assign rem2 = {rem_q, dvd_q[DIV_BITS-1]};
  assign ge   = (rem2 >= {1'b0, dvs_q});

  assign qs = neg_q ? -signed'({3'b0, quot_q}) : signed'({3'b0, quot_q});
  assign tn = TNW'(t_q) - qs;

  assign cur_lt = (acc_q < x_q);
  assign lo_n   = cur_lt ? t_q : lo_q;
  assign hi_n   = cur_lt ? hi_q : t_q;
  assign sum    = {1'b0, lo_n} + {1'b0, hi_n};
  assign mid    = AW'(sum >> 1);

  // Q.30 to Q.16, rounded to nearest with ties away from zero.
  assign ymag  = abs_v(acc_q);
  assign rmag  = (ymag + RND_HALF) >> QIN_SH;
  assign y_rnd = acc_q[VW-1] ? -signed'(rmag) : signed'(rmag);

  always_comb begin
    if (cfg_i.mode == MODE_HOLD) fast_val = '0;
    else if (cfg_i.mode == MODE_BEZIER) fast_val = (progress_i <= 0) ? '0 : ONE16;
    else fast_val = sat_out(VW'(progress_i));
  end

  assign sts_o.fast      = (cfg_i.mode != MODE_BEZIER) || (progress_i <= 0) ||
                           (progress_i >= ONE16);
  assign sts_o.err_small = (abs_v(err_c) < EPS);
  assign sts_o.d_small   = (d_abs < EPS);
  assign sts_o.stray     = ({2'b0, err_abs} >= {d_abs, 2'b00});
  assign sts_o.t_out     = (tn < 0) || (tn > TNW'(Q_ONE_A));

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      x_q <= VW'(progress_i) <<< QIN_SH;
      t_q <= AW'(progress_i) <<< QIN_SH;
    end
    if (cmd_i.mul_en) prod_q <= prod_c;
    if (cmd_i.acc_clr) acc_q <= '0;
    if (cmd_i.wb_en) begin
      unique case (cmd_i.uop.dst)
        DST_M1:   m1_q  <= AW'(prod_q);
        DST_M4:   m4_q  <= AW'(prod_q);
        DST_M7:   m7_q  <= AW'(prod_q);
        DST_SCR:  scr_q <= AW'(prod_q);
        DST_ACC1: acc_q <= acc_q + prod_q;
        DST_ACC3: acc_q <= acc_q + prod_q + (prod_q <<< 1);
        DST_ACC6: acc_q <= acc_q + (prod_q <<< 1) + (prod_q <<< 2);
        default: ;
      endcase
    end
    if (cmd_i.save_err) err_q <= err_c;
    if (cmd_i.div_load) begin
      // The quotient is known to fit in DIV_BITS bits here.
      rem_q  <= err_abs >> 2;
      dvd_q  <= {err_abs[1:0], {QF{1'b0}}};
      dvs_q  <= d_abs;
      neg_q  <= err_q[VW-1] ^ acc_q[VW-1];
      quot_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q  <= ge ? VW'(rem2 - {1'b0, dvs_q}) : VW'(rem2);
      quot_q <= {quot_q[DIV_BITS-2:0], ge};
      dvd_q  <= dvd_q << 1;
    end
    if (cmd_i.init_bisect) begin
      t_q  <= AW'(x_q);
      lo_q <= '0;
      hi_q <= Q_ONE_A;
    end else if (cmd_i.t_upd) begin
      t_q <= AW'(tn);
    end else if (cmd_i.bis_upd) begin
      lo_q <= lo_n;
      hi_q <= hi_n;
      t_q  <= mid;
    end
    if (cmd_i.res_ld) res_q <= cmd_i.res_fast ? fast_val : sat_out(y_rnd);
  end

  assign eased_value_o = res_q;

endmodule

// File: hdl/cbe_checker.sv
// Port-level checks of the easing solver, bound to the top level.
// Depends on the top level's ports only.
module cbe_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o
);

  // The solver only becomes busy after it took an item.
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an accepted item");

  // A result is never shown while a solve is still running.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // Every finished solve delivers its result as it goes idle.
  a_solve_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("solve ended without a result");

  // A result always follows an accepted item or a running solve.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(start) || $past(busy)))
    else $error("result without an item");

endmodule

bind cubic_bezier_easing_solver cbe_checker u_cbe_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o)
);

// File: sim/tb.sv
// Self-checking testbench of the cubic bezier easing solver.
// Depends on cbe_pkg and cubic_bezier_easing_solver; it drives items and register writes
// and checks every eased value against its own fixed-point predictor.
`timescale 1ns / 1ps

module tb;
  import cbe_pkg::*;

  localparam int CLK_HALF = 2;
  localparam longint CYCLE_LIMIT = 10000000;
  localparam int N_RANDOM = 1280;
  localparam int DRAIN_CYCLES = 1200;

  localparam longint QONE = 64'sd1 << 30;
  localparam longint TOL = 107;

  // Shadow of the configuration registers and the store of expected eased values.
  class ease_scoreboard;
    logic [1:0] mode;
    longint x1, y1, x2, y2;
    logic signed [IW-1:0] pending[$];
    int errors;

    function void reset_regs();
      mode = MODE_LINEAR;
      x1 = 0;
      y1 = 0;
      x2 = 65536;
      y2 = 65536;
      pending.delete();
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      longint v;
      v = val[16:0];
      case (idx)
        REG_MODE: mode = val[1:0];
        REG_X1:   x1 = (v > 65536) ? 65536 : v;
        REG_Y1:   y1 = longint'(signed'(val[18:0]));
        REG_X2:   x2 = (v > 65536) ? 65536 : v;
        REG_Y2:   y2 = longint'(signed'(val[18:0]));
        default: ;
      endcase
    endfunction

    // Products are truncated toward zero, as C division is.
    function longint qmul(longint a, longint b);
      return (a * b) / QONE;
    endfunction

    function longint curve_at(longint p1, longint p2, longint t);
      longint mt;
      mt = QONE - t;
      return qmul(qmul(qmul(mt, mt), t), p1) * 3 + qmul(qmul(qmul(mt, t), t), p2) * 3
             + qmul(qmul(t, t), t);
    endfunction

    function longint slope_at(longint p1, longint p2, longint t);
      longint mt;
      mt = QONE - t;
      return qmul(qmul(mt, mt), p1) * 3 + qmul(qmul(mt, t), p2 - p1) * 6
             + qmul(qmul(t, t), QONE - p2) * 3;
    endfunction

    function longint clip_out(longint v);
      if (v < -131072) return -131072;
      if (v > 196608) return 196608;
      return v;
    endfunction

    // Newton first, then bisection from scratch when Newton gives up.
    function longint solve_curve(longint prog);
      longint x, t, e, d, lo, hi, cur, y;
      bit converged;
      converged = 0;
      if (prog <= 0) return 0;
      if (prog >= 65536) return 65536;
      x = prog * 16384;
      t = x;
      for (int i = 0; i < NEWTON_STEPS_DEF; i++) begin
        e = curve_at(x1 * 16384, x2 * 16384, t) - x;
        if ((e < 0 ? -e : e) < TOL) begin
          converged = 1;
          break;
        end
        d = slope_at(x1 * 16384, x2 * 16384, t);
        if ((d < 0 ? -d : d) < TOL) break;
        t -= (e * QONE) / d;
        if (t < 0 || t > QONE) break;
      end
      if (!converged) begin
        lo = 0;
        hi = QONE;
        t = x;
        for (int i = 0; i < BISECT_STEPS_DEF; i++) begin
          cur = curve_at(x1 * 16384, x2 * 16384, t);
          if (((cur - x) < 0 ? x - cur : cur - x) < TOL) break;
          if (cur < x) lo = t;
          else hi = t;
          t = (lo + hi) >>> 1;
        end
      end
      y = curve_at(y1 * 16384, y2 * 16384, t);
      if (y >= 0) y = (y + 8192) / 16384;
      else y = -((-y + 8192) / 16384);
      return clip_out(y);
    endfunction

    function void note_item(logic signed [IW-1:0] prog);
      longint r;
      if (mode == MODE_HOLD) r = 0;
      else if (mode == MODE_BEZIER) r = solve_curve(longint'(prog));
      else r = clip_out(longint'(prog));
      pending.push_back(IW'(r));
    endfunction

    function void check_value(logic signed [IW-1:0] got);
      logic signed [IW-1:0] want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected eased value %0d", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (want !== got) begin
        $display("%0t: eased_value expected %0d actual %0d", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic pready;
  logic start = 0;
  logic busy;
  logic signed [IW-1:0] progress_i = '0;
  logic done_o;
  logic signed [IW-1:0] eased_value_o;

  ease_scoreboard sb;
  longint cycles = 0;
  bit gaps_on = 1;

  cubic_bezier_easing_solver dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .progress_i, .done_o, .eased_value_o
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Results cannot be held off, so every strobe is checked on the edge that takes it.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && done_o) sb.check_value(eased_value_o);
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Register write: setup cycle, then access cycle; pready is always high.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= AddrW'({idx, 2'b00});
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    if (pready) sb.write_reg(idx, val);
    @(negedge clk_i);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  // Holds start high until the block takes the item, with an optional idle burst first.
  task automatic send_item(logic signed [IW-1:0] prog);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    start <= 1;
    progress_i <= prog;
    do @(posedge clk_i); while (busy);
    sb.note_item(prog);
    @(negedge clk_i);
  endtask

  // The solver may still be working, so idle out its worst latency before any write.
  task automatic settle();
    start <= 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic signed [IW-1:0] rand_progress();
    case ($urandom_range(0, 5))
      0: return IW'($urandom_range(0, 262143));
      1: return IW'($urandom_range(0, 196608)) - IW'(65536);
      default: return IW'($urandom_range(1, 65535));
    endcase
  endfunction

  task automatic rand_curve();
    write_reg(REG_X1, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 65536));
    write_reg(REG_Y1, $urandom);
    write_reg(REG_X2, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 65536));
    write_reg(REG_Y2, $urandom);
  endtask

  initial begin
    logic signed [IW-1:0] edge_vals[8];
    sb = new();
    sb.reset_regs();
    edge_vals = '{-19'sd262144, 19'sd262143, 19'sd0, 19'sd65536, 19'sd1, 19'sd65535,
                  -19'sd1, 19'sd32768};
    repeat (6) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // Directed part: linear with saturation at both ends, then hold, then bezier.
    foreach (edge_vals[i]) send_item(edge_vals[i]);
    settle();
    write_reg(REG_MODE, 32'(MODE_HOLD));
    send_item(19'sd12345);
    send_item(-19'sd262144);
    settle();
    write_reg(REG_MODE, 32'(MODE_BEZIER));
    foreach (edge_vals[i]) send_item(edge_vals[i]);
    settle();
    // Y points at their extremes, x1 written out of range and x2 at zero.
    write_reg(REG_X1, 32'h0001_FFFF);
    write_reg(REG_Y1, 32'h0004_0000);
    write_reg(REG_X2, 32'd0);
    write_reg(REG_Y2, 32'h0003_FFFF);
    send_item(19'sd100);
    send_item(19'sd32768);
    send_item(19'sd65000);
    settle();
    write_reg(REG_MODE, 32'd3);
    send_item(19'sd200000);
    send_item(-19'sd100000);
    settle();

    // Random part in phases of random curves and modes, mostly bezier.
    for (int ph = 0; ph < 40; ph++) begin
      write_reg(REG_MODE, $urandom_range(0, 9) < 7 ? 32'(MODE_BEZIER) : $urandom);
      if (ph % 4 == 0) write_reg(3'($urandom_range(5, 7)), $urandom);
      rand_curve();
      if (ph >= 34) gaps_on = 0;
      repeat (N_RANDOM / 40) send_item(rand_progress());
      settle();
    end

    if (sb.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
